@@ hdl/tfls_pkg.sv @@
// ----------------------------------------------------------------------------
// tfls_pkg
// Shared types, constants and the flow hash for the per-flow statistics table.
// ----------------------------------------------------------------------------
package tfls_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int KEY_W         = 96;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] TCP_OFFSET     = 16'd34;
  localparam logic [15:0] TCP_END        = 16'd54;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  typedef enum logic [3:0] {
    ST_SHORT_ETH  = 4'd0,
    ST_NOT_IPV4   = 4'd1,
    ST_SHORT_IP   = 4'd2,
    ST_NOT_TCP    = 4'd3,
    ST_SHORT_TCP  = 4'd4,
    ST_NEW_FLOW   = 4'd5,
    ST_FLOW_UPD   = 4'd6,
    ST_RX_NO_FLOW = 4'd7,
    ST_RX_ACC     = 4'd8,
    ST_TABLE_FULL = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CHECK,
    BK_UPDATE
  } bk_state_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic              reject;
    logic              receive;
    status_t           rej_status;
    logic [KEY_W-1:0]  key;
    logic [15:0]       flen;
    logic [63:0]       etime;
    logic [31:0]       pid;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [63:0]       arrival;
    logic [63:0]       dsum;
    logic [63:0]       bytes;
    logic [63:0]       pkts;
    logic [31:0]       pid;
  } entry_t;

  // Fold the 96-bit key into a table index.
  function automatic logic [IDX_W-1:0] flow_hash(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    return h;
  endfunction

endpackage

@@ hdl/tfls_front.sv @@
// ----------------------------------------------------------------------------
// tfls_front
// Accepts input items, runs the header checks and builds the queue entry.
// ----------------------------------------------------------------------------
module tfls_front
  import tfls_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dst_port,
  input  logic [15:0] in_frame_length,
  input  logic [63:0] in_event_time,
  input  logic [31:0] in_process_id,
  input  logic        clearing,
  input  logic        q_full,
  output logic        push,
  output req_t        push_data
);

  assign in_ready = !clearing && !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_data.receive    = in_operation;
    push_data.key        = {in_source_address, in_dest_address,
                            in_source_port, in_dst_port};
    push_data.flen       = in_frame_length;
    push_data.etime      = in_event_time;
    push_data.pid        = in_process_id;
    push_data.reject     = 1'b0;
    push_data.rej_status = ST_SHORT_ETH;
    // Check order follows the header layout.
    if (!in_operation) begin
      if (in_frame_length < ETH_HDR_LEN) begin
        push_data.reject = 1'b1;
        push_data.rej_status = ST_SHORT_ETH;
      end else if (in_ether_type != ETHERTYPE_IPV4) begin
        push_data.reject = 1'b1;
        push_data.rej_status = ST_NOT_IPV4;
      end else if (in_frame_length < TCP_OFFSET) begin
        push_data.reject = 1'b1;
        push_data.rej_status = ST_SHORT_IP;
      end else if (in_ip_protocol != PROTO_TCP) begin
        push_data.reject = 1'b1;
        push_data.rej_status = ST_NOT_TCP;
      end else if (in_frame_length < TCP_END) begin
        push_data.reject = 1'b1;
        push_data.rej_status = ST_SHORT_TCP;
      end
    end
  end

endmodule

@@ hdl/tfls_queue.sv @@
// ----------------------------------------------------------------------------
// tfls_queue
// Short queue that decouples the front from the table engine.
// ----------------------------------------------------------------------------
module tfls_queue
  import tfls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  input  logic pop,
  output logic q_full,
  output logic q_valid,
  output req_t q_data
);

  req_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign q_full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hdl/tfls_back.sv @@
// ----------------------------------------------------------------------------
// tfls_back
// Table engine: hashed lookup with linear probing, update and result register.
// ----------------------------------------------------------------------------
module tfls_back
  import tfls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  req_t        q_data,
  output logic        pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [63:0] out_latency,
  output logic [63:0] out_flow_delay_sum,
  output logic [63:0] out_flow_byte_total,
  output logic [63:0] out_flow_packet_total,
  output logic [31:0] out_flow_receiver_pid
);

  entry_t     mem [TABLE_ENTRIES];
  entry_t     rd_data_r;
  bk_state_t  state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  req_t       req_r, req_nxt;
  entry_t     ent_r, ent_nxt;
  logic [63:0] lat_r, lat_nxt;
  status_t    res_r, res_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     o_status_r, o_status_nxt;
  logic [63:0] o_lat_r, o_lat_nxt;
  logic [63:0] o_dsum_r, o_dsum_nxt;
  logic [63:0] o_bytes_r, o_bytes_nxt;
  logic [63:0] o_pkts_r, o_pkts_nxt;
  logic [31:0] o_pid_r, o_pid_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic             out_free;
  logic             key_hit;

  assign out_free = !out_valid_r || out_ready;
  assign key_hit  = rd_data_r.valid && (rd_data_r.key == req_r.key);
  assign clearing = (state_r == BK_CLEAR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (addr_r == IDX_W'(TABLE_ENTRIES-1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid && !q_data.reject) state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        if (!rd_data_r.valid || key_hit || cnt_r == IDX_W'(TABLE_ENTRIES-1)) begin
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    ent_nxt       = ent_r;
    lat_nxt       = lat_r;
    res_nxt       = res_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = ent_r;
    rd_addr       = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_status_nxt  = o_status_r;
    o_lat_nxt     = o_lat_r;
    o_dsum_nxt    = o_dsum_r;
    o_bytes_nxt   = o_bytes_r;
    o_pkts_nxt    = o_pkts_r;
    o_pid_nxt     = o_pid_r;
    case (state_r)
      BK_CLEAR: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        addr_nxt = addr_r + 1'b1;
      end
      BK_IDLE: begin
        rd_addr = flow_hash(q_data.key);
        if (q_valid) begin
          if (q_data.reject) begin
            if (out_free) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              o_status_nxt  = q_data.rej_status;
              o_lat_nxt     = '0;
              o_dsum_nxt    = '0;
              o_bytes_nxt   = '0;
              o_pkts_nxt    = '0;
              o_pid_nxt     = '0;
            end
          end else begin
            pop      = 1'b1;
            req_nxt  = q_data;
            addr_nxt = flow_hash(q_data.key);
            cnt_nxt  = '0;
          end
        end
      end
      BK_CHECK: begin
        ent_nxt = rd_data_r;
        lat_nxt = req_r.etime - rd_data_r.arrival;
        if (!rd_data_r.valid) begin
          res_nxt = req_r.receive ? ST_RX_NO_FLOW : ST_NEW_FLOW;
        end else if (key_hit) begin
          res_nxt = req_r.receive ? ST_RX_ACC : ST_FLOW_UPD;
        end else if (cnt_r == IDX_W'(TABLE_ENTRIES-1)) begin
          res_nxt = req_r.receive ? ST_RX_NO_FLOW : ST_TABLE_FULL;
        end else begin
          // Advance the probe to the next slot.
          addr_nxt = addr_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          rd_addr  = addr_r + 1'b1;
        end
      end
      BK_UPDATE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_r;
          o_lat_nxt     = '0;
          wr_data       = ent_r;
          case (res_r)
            ST_NEW_FLOW: begin
              wr_en           = 1'b1;
              wr_data.valid   = 1'b1;
              wr_data.key     = req_r.key;
              wr_data.arrival = req_r.etime;
              wr_data.dsum    = '0;
              wr_data.bytes   = {48'd0, req_r.flen};
              wr_data.pkts    = 64'd1;
              wr_data.pid     = '0;
            end
            ST_FLOW_UPD: begin
              wr_en           = 1'b1;
              wr_data.arrival = req_r.etime;
              wr_data.bytes   = ent_r.bytes + {48'd0, req_r.flen};
              wr_data.pkts    = ent_r.pkts + 64'd1;
            end
            ST_RX_ACC: begin
              wr_en        = 1'b1;
              wr_data.dsum = ent_r.dsum + lat_r;
              wr_data.pid  = req_r.pid;
              o_lat_nxt    = lat_r;
            end
            default: begin
              wr_en   = 1'b0;
              wr_data = '0;
            end
          endcase
          o_dsum_nxt  = wr_data.dsum;
          o_bytes_nxt = wr_data.bytes;
          o_pkts_nxt  = wr_data.pkts;
          o_pid_nxt   = wr_data.pid;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      addr_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ent_r      <= ent_nxt;
    lat_r      <= lat_nxt;
    res_r      <= res_nxt;
    o_status_r <= o_status_nxt;
    o_lat_r    <= o_lat_nxt;
    o_dsum_r   <= o_dsum_nxt;
    o_bytes_r  <= o_bytes_nxt;
    o_pkts_r   <= o_pkts_nxt;
    o_pid_r    <= o_pid_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = o_status_r;
  assign out_latency           = o_lat_r;
  assign out_flow_delay_sum    = o_dsum_r;
  assign out_flow_byte_total   = o_bytes_r;
  assign out_flow_packet_total = o_pkts_r;
  assign out_flow_receiver_pid = o_pid_r;

endmodule

@@ hdl/tcp_flow_latency_stats_table_top.sv @@
// ----------------------------------------------------------------------------
// tcp_flow_latency_stats_table_top
// Per-flow TCP statistics table: packet and receive events update one entry
// per flow (bytes, packets, arrival time, latency sum, receiver pid).
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  in_       | in_valid / in_ready  | operation, header fields, key, time, pid
//  out_      | out_valid / out_ready| status, latency, flow counters, pid
//
// An item that fails a header check is reported from the engine's idle state;
// any other item is looked up by linear probing of the hashed table (over the
// entry memory) until a free slot, a matching key or a full table ends the
// search, and is then reported. After reset a clearing pass writes every entry,
// with in_ready held low. A two-entry queue lets the front accept while the
// engine works; a stalled result holds in the output register.
// ----------------------------------------------------------------------------
module tcp_flow_latency_stats_table_top
  import tfls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_protocol,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dst_port,
  input  logic [15:0] in_frame_length,
  input  logic [63:0] in_event_time,
  input  logic [31:0] in_process_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [63:0] out_latency,
  output logic [63:0] out_flow_delay_sum,
  output logic [63:0] out_flow_byte_total,
  output logic [63:0] out_flow_packet_total,
  output logic [31:0] out_flow_receiver_pid
);

  logic clearing;
  logic q_full;
  logic push;
  req_t push_data;
  logic pop;
  logic q_valid;
  req_t q_data;

  // Classify at the door: header checks finish here.
  tfls_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_ether_type     (in_ether_type),
    .in_ip_protocol    (in_ip_protocol),
    .in_source_address (in_source_address),
    .in_dest_address   (in_dest_address),
    .in_source_port    (in_source_port),
    .in_dst_port       (in_dst_port),
    .in_frame_length   (in_frame_length),
    .in_event_time     (in_event_time),
    .in_process_id     (in_process_id),
    .clearing          (clearing),
    .q_full            (q_full),
    .push              (push),
    .push_data         (push_data)
  );

  // Hold classified items until the engine is free.
  tfls_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Look up, update and report.
  tfls_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_data                (q_data),
    .pop                   (pop),
    .clearing              (clearing),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_latency           (out_latency),
    .out_flow_delay_sum    (out_flow_delay_sum),
    .out_flow_byte_total   (out_flow_byte_total),
    .out_flow_packet_total (out_flow_packet_total),
    .out_flow_receiver_pid (out_flow_receiver_pid)
  );

endmodule

@@ hdl/tfls_checker.sv @@
// ----------------------------------------------------------------------------
// tfls_checker
// Port-level checks for the flow statistics table, bound to the top level.
// ----------------------------------------------------------------------------
module tfls_checker
  import tfls_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_status,
  input logic [63:0] out_latency,
  input logic [63:0] out_flow_delay_sum,
  input logic [63:0] out_flow_byte_total,
  input logic [63:0] out_flow_packet_total
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status))
    else $error("stalled status changed");

  a_new_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NEW_FLOW |->
      out_flow_packet_total == 64'd1 && out_flow_delay_sum == '0 && out_latency == '0)
    else $error("new flow counters wrong");

  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RX_NO_FLOW || out_status == ST_TABLE_FULL) |->
      out_flow_byte_total == '0 && out_flow_packet_total == '0)
    else $error("missing flow reports counters");

endmodule

bind tcp_flow_latency_stats_table_top tfls_checker u_tfls_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_status            (out_status),
  .out_latency           (out_latency),
  .out_flow_delay_sum    (out_flow_delay_sum),
  .out_flow_byte_total   (out_flow_byte_total),
  .out_flow_packet_total (out_flow_packet_total)
);
